// ===== sv/mwo_pkg.sv =====
// Shared types and constants for the MIDI wavetable oscillator.
`timescale 1ns / 1ps

package mwo_pkg;

  // Table geometry
  localparam int WAVE_DEPTH = 1024;
  localparam int NOTE_DEPTH = 128;
  localparam int WAVE_AW    = $clog2(WAVE_DEPTH);
  localparam int NOTE_AW    = $clog2(NOTE_DEPTH);

  // Word widths
  localparam int WORD_W  = 16;
  localparam int FRAC_W  = 6;
  localparam int WEIGHT_W = FRAC_W + 1;

  // Reset values
  localparam logic [WORD_W-1:0] TUNING_RESET = 16'd699;
  localparam logic [WORD_W-1:0] FREQ_RESET   = 16'd1760;

  // Interpolation weight for a full step
  localparam logic [WEIGHT_W-1:0] FRAC_ONE = 7'd64;

  // Item mode codes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_MIDI  = 2'd1;
  localparam logic [1:0] MODE_WAVE  = 2'd2;
  localparam logic [1:0] MODE_NOTE  = 2'd3;

  // Result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_NOTE   = 1'b1;

  // High nibble of a note-on status byte
  localparam logic [3:0] STATUS_NOTE_ON = 4'h9;

  typedef struct packed {
    logic [1:0]         mode;
    logic [WAVE_AW-1:0] address;
    logic [WORD_W-1:0]  data;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [WORD_W-1:0] sample;
    logic [WORD_W-1:0] frequency;
  } out_item_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PHASE,
    ST_MULT,
    ST_SUM,
    ST_NOTE,
    ST_EMIT
  } seq_state_t;

  // MIDI note-on parser states
  typedef enum logic [1:0] {
    PS_WAIT,
    PS_KEY,
    PS_VEL
  } parse_state_t;

  // Controls from the sequencer to the oscillator datapath
  typedef struct packed {
    logic step_ld;
    logic phase_adv;
    logic prod_ld;
    logic held_ld;
  } osc_ctrl_t;

endpackage

// ===== sv/mwo_wave_ram.sv =====
// Wave table memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module mwo_wave_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [mwo_pkg::WAVE_AW-1:0]  wr_addr,
  input  logic [mwo_pkg::WORD_W-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [mwo_pkg::WAVE_AW-1:0]  rd_addr_a,
  input  logic [mwo_pkg::WAVE_AW-1:0]  rd_addr_b,
  output logic [mwo_pkg::WORD_W-1:0]   rd_data_a,
  output logic [mwo_pkg::WORD_W-1:0]   rd_data_b
);

  logic [mwo_pkg::WORD_W-1:0] mem [mwo_pkg::WAVE_DEPTH];
  logic [mwo_pkg::WORD_W-1:0] rd_a_r;
  logic [mwo_pkg::WORD_W-1:0] rd_b_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads of two adjacent entries
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== sv/mwo_note_ram.sv =====
// Note-to-frequency table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module mwo_note_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [mwo_pkg::NOTE_AW-1:0]  wr_addr,
  input  logic [mwo_pkg::WORD_W-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [mwo_pkg::NOTE_AW-1:0]  rd_addr,
  output logic [mwo_pkg::WORD_W-1:0]   rd_data
);

  logic [mwo_pkg::WORD_W-1:0] mem [mwo_pkg::NOTE_DEPTH];
  logic [mwo_pkg::WORD_W-1:0] rd_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_r;

endmodule

// ===== sv/mwo_osc_dp.sv =====
// Oscillator datapath: phase step, phase accumulator, wave reads, interpolation.
`timescale 1ns / 1ps

module mwo_osc_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mwo_pkg::osc_ctrl_t           ctrl,
  input  logic [mwo_pkg::WORD_W-1:0]   tuning,
  input  logic [mwo_pkg::WORD_W-1:0]   freq,
  input  logic                         wave_wr_en,
  input  logic [mwo_pkg::WAVE_AW-1:0]  wave_wr_addr,
  input  logic [mwo_pkg::WORD_W-1:0]   wave_wr_data,
  output logic [mwo_pkg::WORD_W-1:0]   held
);

  localparam int W   = mwo_pkg::WORD_W;
  localparam int FW  = mwo_pkg::FRAC_W;
  localparam int WW  = mwo_pkg::WEIGHT_W;
  localparam int PW  = W + WW;
  localparam int AW  = mwo_pkg::WAVE_AW;

  logic [2*W-1:0] step_prod;
  logic [W-1:0]   step_r;
  logic [W-1:0]   phase_r;
  logic [W-1:0]   phase_nxt;
  logic [FW-1:0]  frac_r;
  logic [AW-1:0]  idx_a;
  logic [AW-1:0]  idx_b;
  logic [W-1:0]   wave_a;
  logic [W-1:0]   wave_b;
  logic [WW-1:0]  wt_a;
  logic [WW-1:0]  wt_b;
  logic [PW-1:0]  prod_a_r;
  logic [PW-1:0]  prod_b_r;
  logic [PW:0]    acc;
  logic [W-1:0]   held_r;

  // Phase step: upper half of tuning * frequency
  assign step_prod = tuning * freq;

  always_ff @(posedge clk) begin
    if (ctrl.step_ld) begin
      step_r <= step_prod[2*W-1:W];
    end
  end

  // Phase accumulator, step scaled by four, wraps at 2^16
  assign phase_nxt = phase_r + {step_r[W-3:0], 2'b00};
  assign idx_a     = phase_nxt[W-1:FW];
  assign idx_b     = idx_a + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (ctrl.phase_adv) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.phase_adv) begin
      frac_r <= phase_nxt[FW-1:0];
    end
  end

  mwo_wave_ram u_wave_ram (
    .clk       (clk),
    .wr_en     (wave_wr_en),
    .wr_addr   (wave_wr_addr),
    .wr_data   (wave_wr_data),
    .rd_en     (ctrl.phase_adv),
    .rd_addr_a (idx_a),
    .rd_addr_b (idx_b),
    .rd_data_a (wave_a),
    .rd_data_b (wave_b)
  );

  // Weighted products of the two neighbors
  assign wt_b = {1'b0, frac_r};
  assign wt_a = mwo_pkg::FRAC_ONE - wt_b;

  always_ff @(posedge clk) begin
    if (ctrl.prod_ld) begin
      prod_a_r <= wave_a * wt_a;
      prod_b_r <= wave_b * wt_b;
    end
  end

  // Sum and drop the fraction
  assign acc = {1'b0, prod_a_r} + {1'b0, prod_b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (ctrl.held_ld) begin
      held_r <= acc[FW+W-1:FW];
    end
  end

  assign held = held_r;

endmodule

// ===== sv/midi_wavetable_oscillator.sv =====
// Top level: item sequencer, MIDI note-on parser, note table and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | in_item  (mode, address, data)
//  out     | output    | out_valid/out_stall| out_item (result_kind, sample, frequency)
//  cfg     | input     | cfg_wr_en          | cfg_wr_data (tuning constant)
//
// A sample tick steps through accept with phase-step multiply, phase add
// and wave table read, weighted multiplies, and sum. A note byte passes
// through the note state for the note table read; other items leave the
// sequencer idle, and a completed note-on goes to the emit state.
// Reset is synchronous (rst_n low); the tables are not cleared.
// A stalled result holds in the output register; the block keeps taking
// items and only waits at the end of a new result until the register frees.
`timescale 1ns / 1ps

module midi_wavetable_oscillator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mwo_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mwo_pkg::out_item_t          out_item,
  input  logic                        cfg_wr_en,
  input  logic [mwo_pkg::WORD_W-1:0]  cfg_wr_data
);

  localparam int W  = mwo_pkg::WORD_W;
  localparam int NA = mwo_pkg::NOTE_AW;

  mwo_pkg::seq_state_t   state_r;
  mwo_pkg::seq_state_t   state_nxt;
  mwo_pkg::parse_state_t parse_r;
  mwo_pkg::parse_state_t parse_nxt;
  mwo_pkg::osc_ctrl_t    osc_ctrl;
  mwo_pkg::out_item_t    res_r;
  mwo_pkg::out_item_t    out_item_r;

  logic         accept;
  logic         out_free;
  logic         out_ld;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         is_tick;
  logic         is_midi;
  logic         note_rd;
  logic         freq_ld;
  logic         wave_we;
  logic         note_we;
  logic [W-1:0] tuning_r;
  logic [W-1:0] freq_r;
  logic [W-1:0] held;
  logic [W-1:0] note_word;
  logic [7:0]   midi_byte;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != mwo_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign is_tick   = (in_item.mode == mwo_pkg::MODE_TICK);
  assign is_midi   = (in_item.mode == mwo_pkg::MODE_MIDI);
  assign midi_byte = in_item.data[7:0];

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mwo_pkg::ST_IDLE: begin
        if (accept && is_tick) begin
          state_nxt = mwo_pkg::ST_PHASE;
        end else if (accept && is_midi && parse_r == mwo_pkg::PS_KEY) begin
          state_nxt = mwo_pkg::ST_NOTE;
        end else if (accept && is_midi && parse_r == mwo_pkg::PS_VEL) begin
          state_nxt = mwo_pkg::ST_EMIT;
        end
      end
      mwo_pkg::ST_PHASE: state_nxt = mwo_pkg::ST_MULT;
      mwo_pkg::ST_MULT:  state_nxt = mwo_pkg::ST_SUM;
      mwo_pkg::ST_SUM: begin
        state_nxt = out_free ? mwo_pkg::ST_IDLE : mwo_pkg::ST_EMIT;
      end
      mwo_pkg::ST_NOTE:  state_nxt = mwo_pkg::ST_IDLE;
      mwo_pkg::ST_EMIT: begin
        state_nxt = out_free ? mwo_pkg::ST_IDLE : mwo_pkg::ST_EMIT;
      end
      default: state_nxt = mwo_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    osc_ctrl.step_ld   = accept && is_tick;
    osc_ctrl.phase_adv = (state_r == mwo_pkg::ST_PHASE);
    osc_ctrl.prod_ld   = (state_r == mwo_pkg::ST_MULT);
    osc_ctrl.held_ld   = (state_r == mwo_pkg::ST_SUM);
    out_ld  = ((state_r == mwo_pkg::ST_SUM) || (state_r == mwo_pkg::ST_EMIT)) && out_free;
    note_rd = accept && is_midi && (parse_r == mwo_pkg::PS_KEY);
    freq_ld = (state_r == mwo_pkg::ST_NOTE);
    wave_we = accept && (in_item.mode == mwo_pkg::MODE_WAVE);
    note_we = accept && (in_item.mode == mwo_pkg::MODE_NOTE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mwo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Note-on parser: status, key, velocity
  always_comb begin
    parse_nxt = parse_r;
    if (accept && is_midi) begin
      case (parse_r)
        mwo_pkg::PS_WAIT: begin
          parse_nxt = (midi_byte[7:4] == mwo_pkg::STATUS_NOTE_ON) ?
                      mwo_pkg::PS_KEY : mwo_pkg::PS_WAIT;
        end
        mwo_pkg::PS_KEY: parse_nxt = mwo_pkg::PS_VEL;
        mwo_pkg::PS_VEL: parse_nxt = mwo_pkg::PS_WAIT;
        default: begin
          parse_nxt = (midi_byte[7:4] == mwo_pkg::STATUS_NOTE_ON) ?
                      mwo_pkg::PS_KEY : mwo_pkg::PS_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_r <= mwo_pkg::PS_WAIT;
    end else begin
      parse_r <= parse_nxt;
    end
  end

  // Tuning register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuning_r <= mwo_pkg::TUNING_RESET;
    end else if (cfg_wr_en) begin
      tuning_r <= cfg_wr_data;
    end
  end

  // Note table, read by the key byte
  mwo_note_ram u_note_ram (
    .clk     (clk),
    .wr_en   (note_we),
    .wr_addr (in_item.address[NA-1:0]),
    .wr_data (in_item.data),
    .rd_en   (note_rd),
    .rd_addr (midi_byte[NA-1:0]),
    .rd_data (note_word)
  );

  // Frequency word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r <= mwo_pkg::FREQ_RESET;
    end else if (freq_ld) begin
      freq_r <= note_word;
    end
  end

  mwo_osc_dp u_osc_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (osc_ctrl),
    .tuning       (tuning_r),
    .freq         (freq_r),
    .wave_wr_en   (wave_we),
    .wave_wr_addr (in_item.address),
    .wave_wr_data (in_item.data),
    .held         (held)
  );

  // Pending result, taken with the values before this item's update
  always_ff @(posedge clk) begin
    if (accept && (is_tick || is_midi)) begin
      res_r.result_kind <= is_tick ? mwo_pkg::KIND_SAMPLE : mwo_pkg::KIND_NOTE;
      res_r.sample      <= held;
      res_r.frequency   <= freq_r;
    end
  end

  // Output register
  assign out_valid_nxt = out_ld || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_item_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
